FILE: rtl/clbs_pkg.sv
// Shared types, codes and constant tables of the character LCD bus sequencer.
package clbs_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned COL_W    = 5;
  localparam int unsigned WAIT_W   = 15;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CMD     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHAR    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CHAR_AT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_WIDTH_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH_US = 1'd1;

  localparam logic [ROW_W-1:0] ROW_1 = 3'd1;
  localparam logic [ROW_W-1:0] ROW_2 = 3'd2;
  localparam logic [ROW_W-1:0] ROW_3 = 3'd3;
  localparam logic [ROW_W-1:0] ROW_4 = 3'd4;

  localparam logic [BYTE_W-1:0] ROW1_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] ROW2_BASE = 8'hC0;
  localparam logic [BYTE_W-1:0] ROW3_BASE = 8'h94;
  localparam logic [BYTE_W-1:0] ROW4_BASE = 8'hD4;

  localparam logic [WAIT_W-1:0] WAIT_POWER_US  = 15'd20000;
  localparam logic [WAIT_W-1:0] WAIT_SECOND_US = 15'd5000;
  localparam logic [WAIT_W-1:0] WAIT_THIRD_US  = 15'd150;

  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd8;

  // Controller to datapath
  typedef struct packed {
    logic              load_req;
    logic              load_out;
    logic [STEP_W-1:0] step_idx;
    logic              nib_lo;
    logic              last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                has_base;
    logic                nibble_mode;
  } dp_status_t;

  // Byte of the power-on init sequence at a given step
  function automatic logic [BYTE_W-1:0] init_cmd(input logic [STEP_W-1:0] idx,
                                                 input logic nibble_mode);
    logic [BYTE_W-1:0] cmd;
    unique case (idx)
      4'd0, 4'd1, 4'd2: cmd = 8'h38;
      4'd3:             cmd = 8'h01;
      4'd4:             cmd = 8'h02;
      4'd5:             cmd = 8'h06;
      4'd6:             cmd = 8'h0C;
      4'd7:             cmd = nibble_mode ? 8'h28 : 8'h38;
      4'd8:             cmd = 8'h80;
      default:          cmd = 8'h00;
    endcase
    return cmd;
  endfunction

  function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] idx);
    logic [WAIT_W-1:0] w;
    unique case (idx)
      4'd0:    w = WAIT_POWER_US;
      4'd1:    w = WAIT_SECOND_US;
      4'd2:    w = WAIT_THIRD_US;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/clbs_req_if.sv
// Request channel: valid/ready handshake with the request fields.
interface clbs_req_if;
  logic                           valid;
  logic                           ready;
  logic [clbs_pkg::OPCODE_W-1:0]  opcode;
  logic [clbs_pkg::BYTE_W-1:0]    value;
  logic [clbs_pkg::ROW_W-1:0]     row;
  logic [clbs_pkg::COL_W-1:0]     column;

  modport source (output valid, opcode, value, row, column, input ready);
  modport sink   (input valid, opcode, value, row, column, output ready);
endinterface

FILE: rtl/clbs_res_if.sv
// Result channel: valid/ready handshake with one strobe description.
interface clbs_res_if;
  logic                          valid;
  logic                          ready;
  logic                          reg_select;
  logic [clbs_pkg::BYTE_W-1:0]   bus_value;
  logic [clbs_pkg::WAIT_W-1:0]   wait_before_us;
  logic                          last;

  modport source (output valid, reg_select, bus_value, wait_before_us, last, input ready);
  modport sink   (input valid, reg_select, bus_value, wait_before_us, last, output ready);
endinterface

FILE: rtl/clbs_ctrl.sv
// Sequencing controller: steps through the bytes and nibbles of one request.
module clbs_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  input  clbs_pkg::dp_status_t    status_i,
  output clbs_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [clbs_pkg::STEP_W-1:0] idx_q, idx_d;
  logic                        nib_q, nib_d;
  logic [clbs_pkg::STEP_W-1:0] last_idx;
  logic                        last_strobe;

  always_comb begin
    unique case (status_i.opcode)
      clbs_pkg::OP_INIT:    last_idx = clbs_pkg::INIT_LAST_STEP;
      clbs_pkg::OP_CMD:     last_idx = '0;
      clbs_pkg::OP_CHAR:    last_idx = '0;
      clbs_pkg::OP_CHAR_AT: last_idx = status_i.has_base ? 4'd1 : 4'd0;
    endcase
  end

  // final strobe: last byte, and its low nibble when on the nibble bus
  assign last_strobe = (idx_q == last_idx) && (!status_i.nibble_mode || nib_q);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    nib_d   = nib_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_LOAD;
          idx_d   = '0;
          nib_d   = 1'b0;
        end
      end
      ST_LOAD: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (res_ready_i) begin
          if (last_strobe) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_LOAD;
            if (status_i.nibble_mode && !nib_q) begin
              nib_d = 1'b1;
            end else begin
              nib_d = 1'b0;
              idx_d = idx_q + 4'd1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      nib_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      nib_q   <= nib_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_SHOW);

  assign cmd_o.load_req = (state_q == ST_IDLE) && req_valid_i;
  assign cmd_o.load_out = (state_q == ST_LOAD);
  assign cmd_o.step_idx = idx_q;
  assign cmd_o.nib_lo   = nib_q;
  assign cmd_o.last     = last_strobe;

endmodule

FILE: rtl/clbs_dp.sv
// Datapath: request hold, cursor address, bus mode register and strobe register.
module clbs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [clbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [clbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [clbs_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [clbs_pkg::BYTE_W-1:0]      value_i,
  input  logic [clbs_pkg::ROW_W-1:0]       row_i,
  input  logic [clbs_pkg::COL_W-1:0]       column_i,
  input  clbs_pkg::ctrl_cmd_t              cmd_i,
  output clbs_pkg::dp_status_t             status_o,
  output logic                             reg_select_o,
  output logic [clbs_pkg::BYTE_W-1:0]      bus_value_o,
  output logic [clbs_pkg::WAIT_W-1:0]      wait_before_us_o,
  output logic                             last_o
);

  logic                          mode_q;
  logic [clbs_pkg::OPCODE_W-1:0] op_q;
  logic [clbs_pkg::BYTE_W-1:0]   val_q;
  logic                          has_base_q;
  logic [clbs_pkg::BYTE_W-1:0]   addr_q;

  logic [clbs_pkg::BYTE_W-1:0]   row_base;
  logic                          has_base;
  logic [clbs_pkg::BYTE_W-1:0]   cur_addr;
  logic [clbs_pkg::BYTE_W-1:0]   cur_byte;
  logic                          cur_rs;
  logic [clbs_pkg::BYTE_W-1:0]   cur_bus;
  logic [clbs_pkg::WAIT_W-1:0]   cur_wait;

  logic                          rs_q;
  logic [clbs_pkg::BYTE_W-1:0]   bus_q;
  logic [clbs_pkg::WAIT_W-1:0]   wait_q;
  logic                          last_q;

  // only the bus mode affects the strobes; the enable width belongs to the pin driver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i && (cfg_idx_i == clbs_pkg::CFG_BUS_WIDTH_MODE)) begin
      mode_q <= cfg_data_i[0];
    end
  end

  always_comb begin
    has_base = 1'b1;
    unique case (row_i)
      clbs_pkg::ROW_1: row_base = clbs_pkg::ROW1_BASE;
      clbs_pkg::ROW_2: row_base = clbs_pkg::ROW2_BASE;
      clbs_pkg::ROW_3: row_base = clbs_pkg::ROW3_BASE;
      clbs_pkg::ROW_4: row_base = clbs_pkg::ROW4_BASE;
      default: begin
        row_base = '0;
        has_base = 1'b0;
      end
    endcase
  end

  // column counts from one; wraps to eight bits
  assign cur_addr = row_base + {3'b000, column_i} + 8'hFF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= clbs_pkg::OP_INIT;
      has_base_q <= 1'b0;
    end else if (cmd_i.load_req) begin
      op_q       <= opcode_i;
      has_base_q <= has_base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      val_q  <= value_i;
      addr_q <= cur_addr;
    end
  end

  always_comb begin
    unique case (op_q)
      clbs_pkg::OP_INIT: begin
        cur_byte = clbs_pkg::init_cmd(cmd_i.step_idx, mode_q);
        cur_rs   = 1'b0;
      end
      clbs_pkg::OP_CMD: begin
        cur_byte = val_q;
        cur_rs   = 1'b0;
      end
      clbs_pkg::OP_CHAR: begin
        cur_byte = val_q;
        cur_rs   = 1'b1;
      end
      clbs_pkg::OP_CHAR_AT: begin
        if (has_base_q && (cmd_i.step_idx == '0)) begin
          cur_byte = addr_q;
          cur_rs   = 1'b0;
        end else begin
          cur_byte = val_q;
          cur_rs   = 1'b1;
        end
      end
    endcase
  end

  // high nibble first on the four-bit bus
  assign cur_bus = mode_q ? {4'b0000, (cmd_i.nib_lo ? cur_byte[3:0] : cur_byte[7:4])}
                          : cur_byte;

  assign cur_wait = (cmd_i.nib_lo || (op_q != clbs_pkg::OP_INIT)) ? '0
                  : clbs_pkg::init_wait(cmd_i.step_idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rs_q   <= cur_rs;
      bus_q  <= cur_bus;
      wait_q <= cur_wait;
      last_q <= cmd_i.last;
    end
  end

  assign status_o.opcode      = op_q;
  assign status_o.has_base    = has_base_q;
  assign status_o.nibble_mode = mode_q;

  assign reg_select_o     = rs_q;
  assign bus_value_o      = bus_q;
  assign wait_before_us_o = wait_q;
  assign last_o           = last_q;

endmodule

FILE: rtl/char_lcd_bus_sequencer_unit.sv
// Top level of the character LCD bus sequencer.
// Takes one request at a time (init sequence, command byte, character byte, or
// character at row and column) and gives one result per enable strobe: register
// select, data-bus value and the wait before the strobe, with last on the final
// strobe. A request is accepted only while the unit is idle; after acceptance
// each strobe is first loaded into the strobe register, then presented until the
// sink takes it, and the sink may stall the unit. A request gives 18 strobes for
// init on the 4-bit bus, 9 on the 8-bit bus, 1 to 4 for the other requests. The
// waits are carried as fields for the pin driver and are not timed here;
// enable_high_us (index 1) is accepted on the configuration port but has no
// effect on the results.
module char_lcd_bus_sequencer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [clbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [clbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  clbs_req_if.sink                         req,
  clbs_res_if.source                       res
);

  clbs_pkg::ctrl_cmd_t  cmd;
  clbs_pkg::dp_status_t status;

  clbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .res_valid_o (res.valid),
    .res_ready_i (res.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clbs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (req.opcode),
    .value_i          (req.value),
    .row_i            (req.row),
    .column_i         (req.column),
    .cmd_i            (cmd),
    .status_o         (status),
    .reg_select_o     (res.reg_select),
    .bus_value_o      (res.bus_value),
    .wait_before_us_o (res.wait_before_us),
    .last_o           (res.last)
  );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench of the character LCD bus sequencer: predicted strobes per transfer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        rs;
    logic [clbs_pkg::BYTE_W-1:0] bus;
    logic [clbs_pkg::WAIT_W-1:0] wait_us;
    logic                        last;
  } strobe_t;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned RANDOM_PHASES  = 4;
  localparam int unsigned PHASE_REQUESTS = 20;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [clbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [clbs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  clbs_req_if req_ch();
  clbs_res_if res_ch();

  char_lcd_bus_sequencer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .res        (res_ch)
  );

  // Strobes still owed by the unit, oldest first
  strobe_t         lcd_strobes_due[$];
  strobe_t         pend_strobe;
  bit              pend_valid;
  strobe_t         due_strobe;
  logic            nibble_bus;
  logic [15:0]     enable_hold_us;
  bit              send_gaps;
  bit              sink_stalls;
  int unsigned     mismatches = 0;
  int unsigned     cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_error(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Hold back the newest strobe so that the final one of a request can be marked
  function automatic void emit_strobe(input logic rs, input logic [clbs_pkg::BYTE_W-1:0] bus,
                                      input logic [clbs_pkg::WAIT_W-1:0] wait_us);
    if (pend_valid) lcd_strobes_due.push_back(pend_strobe);
    pend_strobe = '{rs, bus, wait_us, 1'b0};
    pend_valid  = 1'b1;
  endfunction

  function automatic void emit_byte(input logic rs, input logic [clbs_pkg::BYTE_W-1:0] b,
                                    input logic [clbs_pkg::WAIT_W-1:0] wait_us);
    if (nibble_bus) begin
      emit_strobe(rs, {4'h0, b[7:4]}, wait_us);
      emit_strobe(rs, {4'h0, b[3:0]}, '0);
    end else begin
      emit_strobe(rs, b, wait_us);
    end
  endfunction

  function automatic void plan_request(input logic [clbs_pkg::OPCODE_W-1:0] op,
                                       input logic [clbs_pkg::BYTE_W-1:0] value,
                                       input logic [clbs_pkg::ROW_W-1:0] row,
                                       input logic [clbs_pkg::COL_W-1:0] column);
    int                          i;
    logic [clbs_pkg::BYTE_W-1:0] cmd;
    logic [clbs_pkg::BYTE_W-1:0] base;
    logic [clbs_pkg::WAIT_W-1:0] wait_us;
    bit                          has_base;
    pend_valid = 1'b0;
    has_base   = 1'b1;
    base       = '0;
    case (op)
      clbs_pkg::OP_INIT: begin
        for (i = 0; i < 9; i++) begin
          case (i)
            0, 1, 2: cmd = 8'h38;
            3:       cmd = 8'h01;
            4:       cmd = 8'h02;
            5:       cmd = 8'h06;
            6:       cmd = 8'h0C;
            7:       cmd = nibble_bus ? 8'h28 : 8'h38;
            default: cmd = 8'h80;
          endcase
          case (i)
            0:       wait_us = clbs_pkg::WAIT_POWER_US;
            1:       wait_us = clbs_pkg::WAIT_SECOND_US;
            2:       wait_us = clbs_pkg::WAIT_THIRD_US;
            default: wait_us = '0;
          endcase
          emit_byte(1'b0, cmd, wait_us);
        end
      end
      clbs_pkg::OP_CMD:  emit_byte(1'b0, value, '0);
      clbs_pkg::OP_CHAR: emit_byte(1'b1, value, '0);
      default: begin
        case (row)
          clbs_pkg::ROW_1: base = clbs_pkg::ROW1_BASE;
          clbs_pkg::ROW_2: base = clbs_pkg::ROW2_BASE;
          clbs_pkg::ROW_3: base = clbs_pkg::ROW3_BASE;
          clbs_pkg::ROW_4: base = clbs_pkg::ROW4_BASE;
          default:         has_base = 1'b0;
        endcase
        // Address wraps at eight bits, so column zero and columns past 20 still land somewhere
        if (has_base) emit_byte(1'b0, base + {3'b000, column} - 8'd1, '0);
        emit_byte(1'b1, value, '0);
      end
    endcase
    pend_strobe.last = 1'b1;
    lcd_strobes_due.push_back(pend_strobe);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (lcd_strobes_due.size() == 0) begin
        flag_error($sformatf("strobe rs=%0b bus=%02h with none expected",
                             res_ch.reg_select, res_ch.bus_value));
      end else begin
        due_strobe = lcd_strobes_due.pop_front();
        if (res_ch.reg_select !== due_strobe.rs)
          flag_error($sformatf("reg_select %0b, expected %0b",
                               res_ch.reg_select, due_strobe.rs));
        if (res_ch.bus_value !== due_strobe.bus)
          flag_error($sformatf("bus_value %02h, expected %02h",
                               res_ch.bus_value, due_strobe.bus));
        if (res_ch.wait_before_us !== due_strobe.wait_us)
          flag_error($sformatf("wait_before_us %0d, expected %0d",
                               res_ch.wait_before_us, due_strobe.wait_us));
        if (res_ch.last !== due_strobe.last)
          flag_error($sformatf("last %0b, expected %0b", res_ch.last, due_strobe.last));
      end
    end
  end

  // Result sink: ready drops in random bursts while stalls are enabled
  initial begin : sink_side
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && sink_stalls && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left != 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = rst_ni;
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input logic [clbs_pkg::OPCODE_W-1:0] op,
                              input logic [clbs_pkg::BYTE_W-1:0] value,
                              input logic [clbs_pkg::ROW_W-1:0] row,
                              input logic [clbs_pkg::COL_W-1:0] column);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    req_ch.opcode = op;
    req_ch.value  = value;
    req_ch.row    = row;
    req_ch.column = column;
    req_ch.valid  = 1'b1;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    plan_request(op, value, row, column);
    @(negedge clk_i);
  endtask

  // Hold the sender until every owed strobe has come, then let the unit settle
  task automatic drain_results();
    req_ch.valid = 1'b0;
    while (lcd_strobes_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [clbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [clbs_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    if (idx == clbs_pkg::CFG_BUS_WIDTH_MODE) nibble_bus = data[0];
    else enable_hold_us = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_reset_nibble_bus();
    send_request(clbs_pkg::OP_INIT, 8'hFF, 3'd7, 5'd31);
    send_request(clbs_pkg::OP_CMD, 8'h00, 3'd0, 5'd0);
    send_request(clbs_pkg::OP_CMD, 8'hFF, 3'd7, 5'd31);
    send_request(clbs_pkg::OP_CHAR, 8'h00, 3'd0, 5'd0);
    send_request(clbs_pkg::OP_CHAR, 8'hFF, 3'd7, 5'd31);
  endtask

  task automatic test_cursor_rows();
    send_request(clbs_pkg::OP_CHAR_AT, 8'h41, clbs_pkg::ROW_1, 5'd1);
    send_request(clbs_pkg::OP_CHAR_AT, 8'h42, clbs_pkg::ROW_2, 5'd20);
    send_request(clbs_pkg::OP_CHAR_AT, 8'h43, clbs_pkg::ROW_3, 5'd0);
    send_request(clbs_pkg::OP_CHAR_AT, 8'hFF, clbs_pkg::ROW_4, 5'd31);
    // rows outside one to four skip the cursor command
    send_request(clbs_pkg::OP_CHAR_AT, 8'h00, 3'd0, 5'd5);
    send_request(clbs_pkg::OP_CHAR_AT, 8'h55, 3'd5, 5'd10);
    send_request(clbs_pkg::OP_CHAR_AT, 8'hAA, 3'd6, 5'd31);
    send_request(clbs_pkg::OP_CHAR_AT, 8'h7E, 3'd7, 5'd1);
  endtask

  task automatic test_byte_bus();
    drain_results();
    write_reg(clbs_pkg::CFG_BUS_WIDTH_MODE, 16'hFFFE);
    write_reg(clbs_pkg::CFG_ENABLE_HIGH_US, 16'hFFFF);
    send_request(clbs_pkg::OP_INIT, 8'h00, 3'd0, 5'd0);
    send_request(clbs_pkg::OP_CMD, 8'hFF, 3'd1, 5'd1);
    send_request(clbs_pkg::OP_CHAR, 8'h00, 3'd2, 5'd2);
    send_request(clbs_pkg::OP_CHAR_AT, 8'hFF, clbs_pkg::ROW_1, 5'd20);
    send_request(clbs_pkg::OP_CHAR_AT, 8'h31, 3'd7, 5'd1);
  endtask

  task automatic test_nibble_return();
    drain_results();
    write_reg(clbs_pkg::CFG_BUS_WIDTH_MODE, 16'h0001);
    write_reg(clbs_pkg::CFG_ENABLE_HIGH_US, 16'h0001);
    send_request(clbs_pkg::OP_CMD, 8'h5A, 3'd0, 5'd0);
    send_request(clbs_pkg::OP_CHAR, 8'hA5, 3'd0, 5'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned                   phase;
    int unsigned                   n;
    int unsigned                   roll;
    logic [31:0]                   noise;
    logic [clbs_pkg::OPCODE_W-1:0] op;
    logic [clbs_pkg::BYTE_W-1:0]   value;
    logic [clbs_pkg::ROW_W-1:0]    row;
    logic [clbs_pkg::COL_W-1:0]    column;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      noise = $urandom;
      write_reg(clbs_pkg::CFG_BUS_WIDTH_MODE, {noise[15:1], 1'($urandom_range(0, 1))});
      write_reg(clbs_pkg::CFG_ENABLE_HIGH_US, 16'($urandom_range(1, 65535)));
      // last phase runs flat out on both sides
      send_gaps   = (phase != RANDOM_PHASES - 1);
      sink_stalls = (phase != RANDOM_PHASES - 1);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        roll   = $urandom_range(0, 15);
        op     = (roll == 0) ? clbs_pkg::OP_INIT
               : (roll < 5)  ? clbs_pkg::OP_CMD
               : (roll < 9)  ? clbs_pkg::OP_CHAR
               :               clbs_pkg::OP_CHAR_AT;
        value  = 8'($urandom_range(0, 255));
        row    = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
        column = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 20))
                                            : 5'($urandom_range(0, 31));
        send_request(op, value, row, column);
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = clbs_pkg::CFG_BUS_WIDTH_MODE;
    cfg_data_i     = '0;
    req_ch.valid   = 1'b0;
    req_ch.opcode  = clbs_pkg::OP_INIT;
    req_ch.value   = '0;
    req_ch.row     = '0;
    req_ch.column  = '0;
    nibble_bus     = 1'b1;
    enable_hold_us = 16'd5;
    send_gaps      = 1'b1;
    sink_stalls    = 1'b1;
    pend_valid     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_nibble_bus();
    test_cursor_rows();
    test_byte_bus();
    test_nibble_return();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/clbs_pkg.sv
rtl/clbs_req_if.sv
rtl/clbs_res_if.sv
rtl/clbs_ctrl.sv
rtl/clbs_dp.sv
rtl/char_lcd_bus_sequencer_unit.sv
tb/sv/tb.sv
